// File: design/scvd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the quarter-wave sine table of the current vector drive.
// No dependencies. Used by every module of the block.
package scvd_pkg;

	localparam int SINE_FRAC_BITS = 14;
	localparam int ANGLE_BITS     = 10;

	localparam int DIR_W     = 10;
	localparam int CUR_W     = 16;
	localparam int PWM_W     = 10;
	localparam int AMP_W     = 12;
	localparam int MAG_W     = SINE_FRAC_BITS + 1;
	localparam int ROM_IDX_W = ANGLE_BITS - 1;

	localparam int QUARTER_COUNTS = 1 << (ANGLE_BITS - 2);

	localparam int AMP_FULL  = 4095;
	localparam int CUR_FULL  = 3300;
	localparam int AMP_GCD   = 15;
	localparam int AMP_NUM   = AMP_FULL / AMP_GCD;
	localparam int AMP_DEN   = CUR_FULL / AMP_GCD;
	localparam int DEN_SHIFT = 2;
	localparam int DEN_ODD   = AMP_DEN >> DEN_SHIFT;

	localparam int PROD_W     = CUR_W + 9;
	localparam int QIN_W      = PROD_W - 1 - DEN_SHIFT;
	localparam int DIV_SHIFT  = 28;
	localparam longint unsigned DIV_MAGIC =
		((64'd1 << DIV_SHIFT) + 64'(DEN_ODD) - 64'd1) / 64'(DEN_ODD);
	localparam int MAGIC_W    = 23;
	localparam int QPROD_W    = QIN_W + MAGIC_W;

	localparam int PWM_SHIFT = SINE_FRAC_BITS + 2;
	localparam int PWMP_W    = AMP_W + MAG_W;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	typedef struct packed {
		logic plus;
		logic minus;
	} bridge_t;

	typedef logic [MAG_W-1:0] qmag_t [0:QUARTER_COUNTS];

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[123:60];
	endfunction

	// Taylor series of sine in Q60 fixed point, rounded to the table's fraction bits.
	function automatic qmag_t build_qmag();
		qmag_t       tbl;
		logic [63:0] step;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		step = PI_Q60 >> (ANGLE_BITS - 1);
		for (int m = 0; m <= QUARTER_COUNTS; m++) begin
			x    = step * 64'(m);
			x2   = mul_q60(x, x);
			term = x;
			sum  = x;
			for (int n = 1; n <= 14; n++) begin
				term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
				if ((n & 1) != 0) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			sum    = (sum + (64'd1 << (59 - SINE_FRAC_BITS))) >> (60 - SINE_FRAC_BITS);
			tbl[m] = MAG_W'(sum);
		end
		return tbl;
	endfunction

	localparam qmag_t QMAG = build_qmag();

endpackage

// File: design/sine_current_vector_drive_core.sv
`timescale 1ns / 1ps
// An accepted request moves through the stage registers s1, s2, s3 and s4; s4 is the output register.
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// Reset clears the stage valid bits only; payload registers are not reset.
// Stages: sine fold and current magnitude, table read and scale, divide, phase multiply.
// Depends on scvd_pkg and scvd_sine_lookup.
module sine_current_vector_drive_core
	import scvd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    req_type,
	input  logic [DIR_W-1:0]        direction_count,
	input  logic signed [CUR_W-1:0] current_ma,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [PWM_W-1:0]        pwm_a,
	output logic [PWM_W-1:0]        pwm_b,
	output logic                    a_plus,
	output logic                    a_minus,
	output logic                    b_plus,
	output logic                    b_minus
);

	logic                  adv;
	logic [ANGLE_BITS-1:0] idx_b;
	logic [ANGLE_BITS-1:0] idx_a;
	logic [CUR_W-1:0]      cur_u;
	logic [CUR_W-1:0]      cur_abs;

	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	logic                  sleep_s1, sleep_s2, sleep_s3;
	logic [CUR_W-1:0]      cur_abs_s1;
	logic [PROD_W-1:0]     num_prod;
	logic [QIN_W-1:0]      quot_in_s2;
	logic [QPROD_W-1:0]    quot_prod;
	logic [AMP_W-1:0]      amp_s3;

	logic [MAG_W-1:0]      mag_a, mag_b;
	bridge_t               pins_a, pins_b;
	logic [MAG_W-1:0]      mag_a_s3, mag_b_s3;
	bridge_t               pins_a_s3, pins_b_s3;

	logic [PWMP_W-1:0]     pwm_prod_a, pwm_prod_b;
	logic [PWM_W-1:0]      pwm_a_s4, pwm_b_s4;
	bridge_t               pins_a_s4, pins_b_s4;

	assign adv      = ~(valid_s4 & out_stall);
	assign in_stall = valid_s4 & out_stall;

	assign idx_b   = ANGLE_BITS'(direction_count);
	assign idx_a   = idx_b + ANGLE_BITS'(QUARTER_COUNTS);
	assign cur_u   = current_ma;
	assign cur_abs = cur_u[CUR_W-1] ? (~cur_u + CUR_W'(1)) : cur_u;

	scvd_sine_lookup u_lookup_a (
		.clk  (clk),
		.en   (adv),
		.idx  (idx_a),
		.mag  (mag_a),
		.pins (pins_a)
	);

	scvd_sine_lookup u_lookup_b (
		.clk  (clk),
		.en   (adv),
		.idx  (idx_b),
		.mag  (mag_b),
		.pins (pins_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign num_prod  = PROD_W'(cur_abs_s1) * PROD_W'(AMP_NUM);
	assign quot_prod = QPROD_W'(quot_in_s2) * QPROD_W'(DIV_MAGIC);

	always_ff @(posedge clk) begin
		if (adv) begin
			sleep_s1   <= req_type;
			cur_abs_s1 <= cur_abs;

			sleep_s2   <= sleep_s1;
			quot_in_s2 <= num_prod[QIN_W+DEN_SHIFT-1:DEN_SHIFT];

			sleep_s3   <= sleep_s2;
			amp_s3     <= quot_prod[DIV_SHIFT+AMP_W-1:DIV_SHIFT];
			mag_a_s3   <= mag_a;
			mag_b_s3   <= mag_b;
			pins_a_s3  <= pins_a;
			pins_b_s3  <= pins_b;
		end
	end

	assign pwm_prod_a = PWMP_W'(amp_s3) * PWMP_W'(mag_a_s3);
	assign pwm_prod_b = PWMP_W'(amp_s3) * PWMP_W'(mag_b_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			pwm_a_s4  <= sleep_s3 ? '0 : pwm_prod_a[PWM_SHIFT+PWM_W-1:PWM_SHIFT];
			pwm_b_s4  <= sleep_s3 ? '0 : pwm_prod_b[PWM_SHIFT+PWM_W-1:PWM_SHIFT];
			pins_a_s4 <= sleep_s3 ? '0 : pins_a_s3;
			pins_b_s4 <= sleep_s3 ? '0 : pins_b_s3;
		end
	end

	assign out_valid = valid_s4;
	assign pwm_a     = pwm_a_s4;
	assign pwm_b     = pwm_b_s4;
	assign a_plus    = pins_a_s4.plus;
	assign a_minus   = pins_a_s4.minus;
	assign b_plus    = pins_b_s4.plus;
	assign b_minus   = pins_b_s4.minus;

endmodule

// File: design/scvd_sine_lookup.sv
`timescale 1ns / 1ps
// Two-stage sine lookup: quadrant folding, then the quarter-wave table read and bridge pins.
// Depends on scvd_pkg for the table and the bridge pin type.
module scvd_sine_lookup
	import scvd_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] idx,
	output logic [MAG_W-1:0]      mag,
	output bridge_t               pins
);

	logic [1:0]           quad;
	logic [ROM_IDX_W-1:0] r_idx;
	logic [ROM_IDX_W-1:0] fold_idx;
	logic [1:0]           quad_s1;
	logic [ROM_IDX_W-1:0] rom_idx_s1;
	logic [MAG_W-1:0]     mag_rd;
	logic                 mag_zero;
	logic [MAG_W-1:0]     mag_s2;
	bridge_t              pins_s2;

	assign quad     = idx[ANGLE_BITS-1:ANGLE_BITS-2];
	assign r_idx    = ROM_IDX_W'(idx[ANGLE_BITS-3:0]);
	assign fold_idx = quad[0] ? (ROM_IDX_W'(QUARTER_COUNTS) - r_idx) : r_idx;

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1    <= quad;
			rom_idx_s1 <= fold_idx;
		end
	end

	assign mag_rd   = QMAG[rom_idx_s1];
	assign mag_zero = (mag_rd == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2        <= mag_rd;
			pins_s2.plus  <= mag_zero | ~quad_s1[1];
			pins_s2.minus <= mag_zero | quad_s1[1];
		end
	end

	assign mag  = mag_s2;
	assign pins = pins_s2;

endmodule

// File: design/scvd_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the current vector drive core, bound to its top level.
// Depends on scvd_pkg for field widths.
module scvd_checker
	import scvd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [PWM_W-1:0] pwm_a,
	input logic [PWM_W-1:0] pwm_b,
	input logic             a_plus,
	input logic             a_minus,
	input logic             b_plus,
	input logic             b_minus
);

	// A result held under stall keeps every field.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pwm_a) && $stable(pwm_b)
			&& $stable(a_plus) && $stable(a_minus) && $stable(b_plus) && $stable(b_minus))
		else $error("stalled result changed");

	// Requests are only held back while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled without a waiting result");

	// A zero sine on one phase means zero PWM on itself and a nonzero sine on the other.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && a_plus && a_minus |-> pwm_a == '0 && !(b_plus && b_minus))
		else $error("phase A zero crossing inconsistent");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && b_plus && b_minus |-> pwm_b == '0 && !(a_plus && a_minus))
		else $error("phase B zero crossing inconsistent");

	// Sleep turns everything off together.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !a_plus && !a_minus |->
			!b_plus && !b_minus && pwm_a == '0 && pwm_b == '0)
		else $error("partial sleep result");

endmodule

bind sine_current_vector_drive_core scvd_checker u_scvd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pwm_a     (pwm_a),
	.pwm_b     (pwm_b),
	.a_plus    (a_plus),
	.a_minus   (a_minus),
	.b_plus    (b_plus),
	.b_minus   (b_minus)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench of sine_current_vector_drive_core: predicts both coil drives per request and checks them.
// Depends on scvd_pkg and the core; builds its own sine table with $sin for the prediction.
module tb;
	import scvd_pkg::*;

	localparam logic REQ_DRIVE = 1'b0;
	localparam logic REQ_SLEEP = 1'b1;
	localparam int PERIOD_COUNTS = 1 << ANGLE_BITS;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam real PI_REAL = 3.14159265358979323846;

	typedef enum int {PACE_NONE, PACE_NORMAL, PACE_HEAVY} pace_t;

	typedef struct packed {
		logic [PWM_W-1:0] pwm_a;
		logic [PWM_W-1:0] pwm_b;
		bridge_t          phase_a;
		bridge_t          phase_b;
	} coil_drive_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    req_type = REQ_DRIVE;
	logic [DIR_W-1:0]        direction_count = '0;
	logic signed [CUR_W-1:0] current_ma = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [PWM_W-1:0]        pwm_a;
	logic [PWM_W-1:0]        pwm_b;
	logic                    a_plus;
	logic                    a_minus;
	logic                    b_plus;
	logic                    b_minus;

	int unsigned sine_quarter [0:QUARTER_COUNTS];
	coil_drive_t pending_drive [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_hold = 0;
	pace_t       idle_pace = PACE_NONE;
	pace_t       stall_pace = PACE_NONE;

	sine_current_vector_drive_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.direction_count (direction_count),
		.current_ma      (current_ma),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pwm_a           (pwm_a),
		.pwm_b           (pwm_b),
		.a_plus          (a_plus),
		.a_minus         (a_minus),
		.b_plus          (b_plus),
		.b_minus         (b_minus)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int unsigned pick_gap(pace_t pace);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (pace == PACE_NONE) begin
			return 0;
		end else if (pace == PACE_NORMAL) begin
			if (roll < 55) return 0;
			if (roll < 90) return $urandom_range(1, 3);
			return $urandom_range(4, 25);
		end
		if (roll < 20) return 0;
		if (roll < 70) return $urandom_range(1, 4);
		return $urandom_range(5, 30);
	endfunction

	function automatic bridge_t phase_drive(input int unsigned idx, input int unsigned amp,
			output logic [PWM_W-1:0] pwm);
		int unsigned quadrant;
		int unsigned offset;
		int unsigned mag;
		bridge_t     pins;
		quadrant = (idx >> (ANGLE_BITS - 2)) & 3;
		offset   = idx & (QUARTER_COUNTS - 1);
		mag      = quadrant[0] ? sine_quarter[QUARTER_COUNTS - offset] : sine_quarter[offset];
		pwm      = PWM_W'((amp * mag) >> (SINE_FRAC_BITS + 2));
		if (mag == 0) begin
			pins = '{plus: 1'b1, minus: 1'b1};
		end else if (quadrant[1]) begin
			pins = '{plus: 1'b0, minus: 1'b1};
		end else begin
			pins = '{plus: 1'b1, minus: 1'b0};
		end
		return pins;
	endfunction

	function automatic coil_drive_t coil_drive_of(input logic rt, input logic [DIR_W-1:0] dir,
			input logic signed [CUR_W-1:0] cur);
		coil_drive_t drive;
		int unsigned idx_b;
		int unsigned magnitude;
		int unsigned amp;
		drive = '0;
		if (rt == REQ_SLEEP) begin
			return drive;
		end
		idx_b     = dir & (PERIOD_COUNTS - 1);
		magnitude = cur[CUR_W-1] ? (32'h10000 - {16'h0, cur}) : {16'h0, cur};
		amp       = ((magnitude * AMP_FULL) / CUR_FULL) & 32'hFFF;
		drive.phase_a = phase_drive((idx_b + QUARTER_COUNTS) & (PERIOD_COUNTS - 1), amp,
			drive.pwm_a);
		drive.phase_b = phase_drive(idx_b, amp, drive.pwm_b);
		return drive;
	endfunction

	function automatic logic signed [CUR_W-1:0] pick_current();
		int signed sign;
		sign = $urandom_range(0, 1) ? -1 : 1;
		case ($urandom_range(0, 3))
			0: return CUR_W'($urandom);
			1: return CUR_W'(int'($urandom_range(0, 6600)) - 3300);
			2: return CUR_W'(sign * (3300 + int'($urandom_range(0, 10)) - 5));
			default: begin
				case ($urandom_range(0, 4))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return CUR_W'(sign);
					3: return '0;
					default: return CUR_W'(sign * int'($urandom_range(32700, 32767)));
				endcase
			end
		endcase
	endfunction

	function automatic logic [DIR_W-1:0] pick_direction();
		if ($urandom_range(0, 3) != 0) begin
			return DIR_W'($urandom);
		end
		return DIR_W'(int'($urandom_range(0, 3)) * QUARTER_COUNTS + int'($urandom_range(0, 4)) - 2);
	endfunction

	task automatic send_request(input logic rt, input logic [DIR_W-1:0] dir,
			input logic signed [CUR_W-1:0] cur);
		int unsigned gap;
		gap = pick_gap(idle_pace);
		if (gap != 0) begin
			in_valid        <= 1'b0;
			req_type        <= 1'($urandom);
			direction_count <= DIR_W'($urandom);
			current_ma      <= CUR_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		req_type        <= rt;
		direction_count <= dir;
		current_ma      <= cur;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random(input int unsigned count, input int unsigned sleep_pct);
		for (int unsigned k = 0; k < count; k++) begin
			send_request(($urandom_range(0, 99) < sleep_pct) ? REQ_SLEEP : REQ_DRIVE,
				pick_direction(), pick_current());
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic test_directed();
		idle_pace  = PACE_NORMAL;
		stall_pace = PACE_NORMAL;
		send_request(REQ_SLEEP, 10'd1023, -16'sd32768);
		send_request(REQ_DRIVE, 10'd0, 16'sd3300);
		send_request(REQ_DRIVE, 10'd256, 16'sd3300);
		send_request(REQ_DRIVE, 10'd512, -16'sd3300);
		send_request(REQ_DRIVE, 10'd768, 16'sd3300);
		send_request(REQ_SLEEP, 10'd0, 16'sd0);
		send_request(REQ_DRIVE, 10'd1023, 16'sd32767);
		send_request(REQ_DRIVE, 10'd128, -16'sd32768);
		send_request(REQ_DRIVE, 10'd384, -16'sd1);
		send_request(REQ_DRIVE, 10'd640, 16'sd1);
		send_request(REQ_DRIVE, 10'd896, 16'sd0);
		send_request(REQ_DRIVE, 10'd1, 16'sd3301);
		send_request(REQ_DRIVE, 10'd255, 16'sd3299);
		send_request(REQ_DRIVE, 10'd257, -16'sd3301);
		send_request(REQ_DRIVE, 10'd511, -16'sd2000);
		send_request(REQ_DRIVE, 10'd513, 16'sd2000);
		send_request(REQ_DRIVE, 10'd767, 16'sd1650);
		send_request(REQ_DRIVE, 10'd769, -16'sd1650);
		send_request(REQ_DRIVE, 10'h2AA, 16'sh5555);
		send_request(REQ_DRIVE, 10'h155, -16'sh5556);
		send_request(REQ_SLEEP, 10'h155, 16'sh7FFF);
		send_request(REQ_DRIVE, 10'd0, -16'sd32768);
	endtask

	task automatic test_random_mix();
		idle_pace  = PACE_NORMAL;
		stall_pace = PACE_NORMAL;
		send_random(500, 15);
	endtask

	task automatic test_streaming();
		idle_pace  = PACE_NONE;
		stall_pace = PACE_NONE;
		send_random(200, 10);
	endtask

	task automatic test_backpressure();
		idle_pace  = PACE_NONE;
		stall_pace = PACE_HEAVY;
		send_random(150, 10);
	endtask

	task automatic test_sparse_sender();
		idle_pace  = PACE_HEAVY;
		stall_pace = PACE_NORMAL;
		send_random(100, 20);
	endtask

	always @(posedge clk) begin
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (stall_pace == PACE_NONE) begin
			out_stall <= 1'b0;
		end else begin
			out_stall  <= $urandom_range(0, 99) < ((stall_pace == PACE_NORMAL) ? 35 : 75);
			stall_hold <= pick_gap(stall_pace);
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			pending_drive.push_back(coil_drive_of(req_type, direction_count, current_ma));
		end
	end

	always @(posedge clk) begin : check_results
		coil_drive_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_drive.size() == 0) begin
				$error("result with no request outstanding: pwm_a %0d pwm_b %0d", pwm_a, pwm_b);
				mismatch_count++;
			end else begin
				want = pending_drive.pop_front();
				check_field("pwm_a", want.pwm_a, pwm_a);
				check_field("pwm_b", want.pwm_b, pwm_b);
				check_field("a_plus", want.phase_a.plus, a_plus);
				check_field("a_minus", want.phase_a.minus, a_minus);
				check_field("b_plus", want.phase_b.plus, b_plus);
				check_field("b_minus", want.phase_b.minus, b_minus);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sine_current_vector_drive_core test failed");
			$finish;
		end
	end

	initial begin
		real scaled;
		for (int m = 0; m <= QUARTER_COUNTS; m++) begin
			scaled = $sin(PI_REAL * m / (2.0 * QUARTER_COUNTS)) * (2.0 ** SINE_FRAC_BITS);
			sine_quarter[m] = $rtoi($floor(scaled + 0.5));
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix();
		test_streaming();
		test_backpressure();
		test_sparse_sender();
		in_valid <= 1'b0;
		stall_pace = PACE_NORMAL;
		while (pending_drive.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("sine_current_vector_drive_core test passed");
		end else begin
			$display("sine_current_vector_drive_core test failed");
		end
		$finish;
	end

endmodule

// File: files.f
design/scvd_pkg.sv
design/scvd_sine_lookup.sv
design/sine_current_vector_drive_core.sv
design/scvd_checker.sv
dv/tb.sv
